FILE: hdl/mssd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment serial driver package
// Shared constants, types and the segment glyph decoder.
// ----------------------------------------------------------------------------
package mssd_pkg;

	localparam int DIGIT_COUNT_DEF = 4;
	localparam int CODE_W          = 8;
	localparam int WORD_W          = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int VAL_W           = 14;

	localparam logic [CODE_W-1:0] CODE_BLANK   = 8'd16;
	localparam logic [VAL_W-1:0]  NUMBER_LIMIT = 14'd9999;
	localparam logic [VAL_W-1:0]  TEMP_LIMIT   = 14'd999;
	localparam logic [7:0]        DP_SEGMENT   = 8'h80;
	localparam logic [7:0]        POINT_NEG    = 8'h04;
	localparam logic [7:0]        POINT_POS    = 8'h02;

	// Reciprocal constants: x / 100 = (x * 5243) >> 19 for x below 43699,
	// x / 10 = (x * 205) >> 11 for x below 1029.
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam int          DIV100_SH  = 19;
	localparam logic [7:0]  DIV10_MUL  = 8'd205;
	localparam int          DIV10_SH   = 11;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_DIGIT  = 3'd1,
		OP_POINT  = 3'd2,
		OP_NUMBER = 3'd3,
		OP_TEMP   = 3'd4
	} opcode_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Segment byte in the order DP G F E D C B A; blank for codes above 15.
	function automatic logic [7:0] glyph(input logic [CODE_W-1:0] code);
		logic [7:0] seg;
		case (code)
			8'd0:    seg = 8'h3F;
			8'd1:    seg = 8'h06;
			8'd2:    seg = 8'h5B;
			8'd3:    seg = 8'h4F;
			8'd4:    seg = 8'h66;
			8'd5:    seg = 8'h6D;
			8'd6:    seg = 8'h7D;
			8'd7:    seg = 8'h07;
			8'd8:    seg = 8'h7F;
			8'd9:    seg = 8'h6F;
			8'd10:   seg = 8'h77;
			8'd11:   seg = 8'h7C;
			8'd12:   seg = 8'h39;
			8'd13:   seg = 8'h5E;
			8'd14:   seg = 8'h79;
			8'd15:   seg = 8'h71;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

FILE: hdl/mssd_front.sv
// ----------------------------------------------------------------------------
// Seven-segment serial driver front end
// Four-stage pipeline: saturation, decimal split, digit store update and
// tick decode into a sixteen-bit shift word.
// ----------------------------------------------------------------------------
module mssd_front
	import mssd_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          in_op,
	input  logic [2:0]          in_pos,
	input  logic [CODE_W-1:0]   in_code,
	input  logic                in_dp,
	input  logic [15:0]         in_num,
	input  logic                in_lz,
	input  logic signed [15:0]  in_temp,
	input  q_status_t           q_stat,
	output logic                push,
	output logic [WORD_W-1:0]   push_word
);

	localparam int IDX_W = $clog2(DIGIT_COUNT);

	typedef struct packed {
		logic [2:0]        op;
		logic [2:0]        pos;
		logic [CODE_W-1:0] code;
		logic              dp;
		logic              lz;
	} ctl_t;

	logic              v_s1, v_s2, v_s3, v_s4;
	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [15:0]       num_s1, temp_s1;
	logic [VAL_W-1:0]  val_s2, val_s3;
	logic              neg_s2, neg_s3, neg_s4;
	logic [6:0]        hi_s3, lo_s4;
	logic [3:0]        th_s4, hu_s4;

	logic [CODE_W-1:0]      store_q [DIGIT_COUNT];
	logic [DIGIT_COUNT-1:0] mask_q;
	logic [IDX_W-1:0]       idx_q;

	logic              en, is_tick_s4, pos_ok;
	logic [15:0]       tmag;
	logic [VAL_W-1:0]  nsat, tsat, val_d;
	logic [26:0]       prod2;
	logic [6:0]        hi_d, lo_d;
	logic [13:0]       hundred;
	logic [14:0]       p3, p4;
	logic [3:0]        th_d, hu_d, lt, lu;
	logic [CODE_W-1:0] d0, d1, d2, d3, h_bz;
	logic [7:0]        seg, sel;

	assign is_tick_s4 = v_s4 && (ctl_s4.op == OP_TICK);
	assign en         = !(is_tick_s4 && q_stat.full);
	assign in_ready   = en;
	assign push       = is_tick_s4 && !q_stat.full;

	// Stage 1: clamp both candidate values.
	always_comb begin
		tmag  = temp_s1[15] ? (~temp_s1 + 16'd1) : temp_s1;
		nsat  = (num_s1 > 16'd9999) ? NUMBER_LIMIT : num_s1[VAL_W-1:0];
		tsat  = (tmag > 16'd999) ? TEMP_LIMIT : tmag[VAL_W-1:0];
		val_d = (ctl_s1.op == OP_NUMBER) ? nsat : tsat;
	end

	// Stage 2: upper pair of decimal digits.
	assign prod2 = 27'(val_s2) * 27'(DIV100_MUL);
	assign hi_d  = prod2[DIV100_SH+6:DIV100_SH];

	// Stage 3: lower pair and split of the upper pair.
	always_comb begin
		hundred = 14'(hi_s3) * 14'd100;
		lo_d    = 7'(val_s3 - hundred);
		p3      = 15'(hi_s3) * 15'(DIV10_MUL);
		th_d    = p3[DIV10_SH+3:DIV10_SH];
		hu_d    = 4'(hi_s3 - 7'({3'b000, th_d} * 7'd10));
	end

	// Stage 4: split of the lower pair and digit layout.
	always_comb begin
		p4   = 15'(lo_s4) * 15'(DIV10_MUL);
		lt   = p4[DIV10_SH+3:DIV10_SH];
		lu   = 4'(lo_s4 - 7'({3'b000, lt} * 7'd10));
		h_bz = (hu_s4 == 4'd0) ? CODE_BLANK : CODE_W'(hu_s4);
		d0   = CODE_W'(th_s4);
		d1   = CODE_W'(hu_s4);
		d2   = CODE_W'(lt);
		d3   = CODE_W'(lu);
		if (!ctl_s4.lz && th_s4 == 4'd0) begin
			d0 = CODE_BLANK;
			if (hu_s4 == 4'd0) begin
				d1 = CODE_BLANK;
				if (lt == 4'd0) begin
					d2 = CODE_BLANK;
				end
			end
		end
		pos_ok = ({1'b0, ctl_s4.pos} < 4'(DIGIT_COUNT));
	end

	// Tick decode of the digit under the scan index.
	always_comb begin
		seg = glyph(store_q[idx_q]);
		if (mask_q[idx_q]) begin
			seg = seg | DP_SEGMENT;
		end
		sel       = ~(8'h01 << idx_q);
		push_word = {~seg, sel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= '{op: in_op, pos: in_pos, code: in_code, dp: in_dp, lz: in_lz};
			num_s1  <= in_num;
			temp_s1 <= in_temp;
			ctl_s2  <= ctl_s1;
			val_s2  <= val_d;
			neg_s2  <= temp_s1[15];
			ctl_s3  <= ctl_s2;
			val_s3  <= val_s2;
			neg_s3  <= neg_s2;
			hi_s3   <= hi_d;
			ctl_s4  <= ctl_s3;
			neg_s4  <= neg_s3;
			lo_s4   <= lo_d;
			th_s4   <= th_d;
			hu_s4   <= hu_d;
		end
	end

	// Temperature layouts never blank the tens digit, so they take the raw
	// tens and ones rather than the number layout.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				store_q[i] <= '0;
			end
			mask_q <= '0;
			idx_q  <= '0;
		end else if (v_s4 && en) begin
			unique case (ctl_s4.op)
				OP_TICK: begin
					if (idx_q == IDX_W'(DIGIT_COUNT - 1)) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				OP_DIGIT: begin
					if (pos_ok) begin
						store_q[ctl_s4.pos[IDX_W-1:0]] <= ctl_s4.code;
					end
				end
				OP_POINT: begin
					if (pos_ok) begin
						mask_q[ctl_s4.pos[IDX_W-1:0]] <= ctl_s4.dp;
					end
				end
				OP_NUMBER: begin
					store_q[0] <= d0;
					store_q[1] <= d1;
					store_q[2] <= d2;
					store_q[3] <= d3;
				end
				OP_TEMP: begin
					if (neg_s4) begin
						store_q[0] <= CODE_BLANK;
						store_q[1] <= h_bz;
						store_q[2] <= CODE_W'(lt);
						store_q[3] <= d3;
						mask_q     <= POINT_NEG[DIGIT_COUNT-1:0];
					end else begin
						store_q[0] <= h_bz;
						store_q[1] <= CODE_W'(lt);
						store_q[2] <= d3;
						store_q[3] <= CODE_BLANK;
						mask_q     <= POINT_POS[DIGIT_COUNT-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hdl/mssd_queue.sv
// ----------------------------------------------------------------------------
// Seven-segment serial driver word queue
// Small first-in first-out buffer of shift words between front and back.
// ----------------------------------------------------------------------------
module mssd_queue
	import mssd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WORD_W-1:0] push_word,
	input  logic              pop,
	output logic [WORD_W-1:0] pop_word,
	output q_status_t         stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;

	assign stat.full  = (cnt_q == (AW + 1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_word   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/mssd_back.sv
// ----------------------------------------------------------------------------
// Seven-segment serial driver back end
// Shifts each queued word out one bit per output transaction, MSB first.
// ----------------------------------------------------------------------------
module mssd_back
	import mssd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  q_status_t         q_stat,
	input  logic [WORD_W-1:0] pop_word,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_bit,
	output logic              out_last
);

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q, last_q, xfer;
	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  cnt_q;

	assign xfer      = busy_q && out_ready;
	assign pop       = !q_stat.empty && (!busy_q || (xfer && last_q));
	assign out_valid = busy_q;
	assign out_bit   = word_q[WORD_W-1];
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			last_q <= 1'b0;
			cnt_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			last_q <= 1'b0;
			cnt_q  <= '0;
		end else if (xfer) begin
			if (last_q) begin
				busy_q <= 1'b0;
				last_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_q + 1'b1;
				last_q <= (cnt_q == CNT_W'(WORD_W - 2));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= pop_word;
		end else if (xfer) begin
			word_q <= {word_q[WORD_W-2:0], 1'b0};
		end
	end

endmodule

FILE: hdl/mux_seven_segment_serial_driver_top.sv
// ----------------------------------------------------------------------------
// Multiplexed seven-segment serial driver, top level
// Common-anode display controller feeding a chain of two shift registers.
// ----------------------------------------------------------------------------
// Each input transaction carries an opcode in tuser. Writes (digit code,
// decimal point, number, temperature) produce no output and are accepted
// one per cycle while tready is high; they take effect in order with ticks.
// A tick decodes the digit under the scan index and produces
// sixteen output transactions, one serial bit each: the inverted segment
// byte (DP G F E D C B A) MSB first, then the active-low digit select byte,
// with tlast marking the sixteenth bit where the chain is latched. A tick
// therefore occupies the output for sixteen transactions; the serializer
// in the back end is what sets that figure. Ticks are decoded in the front
// pipeline and wait in a two-entry word queue, so writes and further ticks
// keep flowing while the serializer works; input tready drops only while
// a tick sits at the end of the front pipeline and the queue is full.
// ----------------------------------------------------------------------------
module mux_seven_segment_serial_driver_top
	import mssd_pkg::*;
#(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: position[2:0], digit_code[10:3], dp_on[11], number_value[27:12],
	// leading_zeros[28], temperature_tenths[44:29], zero padding[47:45]
	input  logic [47:0] s_axis_tdata,
	// tuser: opcode[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: serial_data[0], zero padding[7:1]
	output logic [7:0]  m_axis_tdata,
	// tlast: latch_strobe
	output logic        m_axis_tlast
);

	q_status_t         q_stat;
	logic              push, pop, serial_bit;
	logic [WORD_W-1:0] push_word, pop_word;

	// The front end owns the digit store, point mask and scan index, so
	// every write is seen by the ticks that follow it in the stream.
	mssd_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_pos    (s_axis_tdata[2:0]),
		.in_code   (s_axis_tdata[10:3]),
		.in_dp     (s_axis_tdata[11]),
		.in_num    (s_axis_tdata[27:12]),
		.in_lz     (s_axis_tdata[28]),
		.in_temp   (s_axis_tdata[44:29]),
		.q_stat    (q_stat),
		.push      (push),
		.push_word (push_word)
	);

	mssd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.stat      (q_stat)
	);

	// The back end reloads from the queue on the sixteenth bit, so
	// consecutive ticks stream without a gap.
	mssd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_word  (pop_word),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_bit   (serial_bit),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {7'b0000000, serial_bit};

endmodule
